>>> hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ZERO_DEN = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMBINE,
        ST_GCD_SHIFT,
        ST_GCD_SUB,
        ST_DIV_INIT,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_CHECK,
        ST_OUT
    } t_state;

endpackage

>>> hw/rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// add, subtract, multiply or divide two fractions and reduce the result
// ----------------------------------------------------------------------------
// One request is taken at a time; the unit is busy until the result has been
// taken. Three cross products go through one 32x32 multiplier (one per
// cycle), then a binary gcd on the 64-bit magnitude and denominator runs
// through the shared 64-bit subtractor (with a second subtract when the
// second operand is the larger) and a shifter, taking shift and subtract
// steps until the two values meet, and finally two restoring divisions by
// the gcd share the same subtractor. Zero-denominator requests go from the
// first multiply state straight to the result, and zero results go from
// the gcd shift state straight to the result, skipping the divisions.
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98], zeros
    input  logic [135:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_num[31:0], res_den[62:32], err[64:63], zeros
    output logic [71:0] m_axis_tdata
);

    localparam logic [63:0] LIM = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    rau_pkg::t_state r_state, n_state;

    logic [1:0]  r_op;
    logic [31:0] r_ma, r_da, r_mb, r_db;
    logic        r_sa, r_sb;
    logic [63:0] r_p, r_q, r_den;        // products
    logic [63:0] r_mag, r_dsave;         // value before reduction
    logic        r_neg;
    logic [63:0] r_ga, r_gb;             // gcd operands
    logic [6:0]  r_k;                    // common power of two
    logic [63:0] r_g;
    logic [63:0] r_quo, r_rem;
    logic [6:0]  r_cnt;
    logic [63:0] r_rnum, r_rden;
    logic [31:0] r_onum;
    logic [30:0] r_oden;
    rau_pkg::t_err r_err;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_y;
    assign mul_y = {32'd0, mul_a} * {32'd0, mul_b};

    // shared subtractor
    logic [63:0] sub_a, sub_b;
    logic [64:0] sub_y;
    assign sub_y = {1'b0, sub_a} - {1'b0, sub_b};

    logic [63:0] in_an, in_ad, in_bn, in_bd;
    assign in_an = 64'(s_axis_tdata[33:2]);
    assign in_ad = 64'(s_axis_tdata[65:34]);
    assign in_bn = 64'(s_axis_tdata[97:66]);
    assign in_bd = 64'(s_axis_tdata[129:98]);

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    logic [63:0] rem_sh;
    assign rem_sh = {r_rem[62:0], r_quo[63]};

    always_comb begin
        mul_a = r_ma;
        mul_b = r_db;
        sub_a = r_ga;
        sub_b = r_gb;
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_MUL1: begin
                mul_a = r_ma; mul_b = r_db;
            end
            rau_pkg::ST_MUL2: begin
                if (rau_pkg::t_op'(r_op) == rau_pkg::OP_MUL) begin
                    mul_a = r_ma; mul_b = r_mb;
                end else if (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) begin
                    mul_a = r_da; mul_b = r_mb;
                end else begin
                    mul_a = r_mb; mul_b = r_da;
                end
            end
            rau_pkg::ST_MUL3: begin
                mul_a = r_da; mul_b = r_db;
            end
            rau_pkg::ST_COMBINE: begin
                sub_a = r_p; sub_b = r_q;
            end
            rau_pkg::ST_GCD_SUB: begin
                sub_a = r_ga; sub_b = r_gb;
            end
            rau_pkg::ST_DIV_NUM, rau_pkg::ST_DIV_DEN: begin
                sub_a = rem_sh; sub_b = r_g;
            end
            default: ;
        endcase
        case (r_state)
            rau_pkg::ST_IDLE:      if (s_axis_tvalid) n_state = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:      n_state = (r_err != rau_pkg::ERR_NONE) ?
                                       rau_pkg::ST_OUT : rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:      n_state = rau_pkg::ST_MUL3;
            rau_pkg::ST_MUL3:      n_state = rau_pkg::ST_COMBINE;
            rau_pkg::ST_COMBINE:   n_state = rau_pkg::ST_GCD_SHIFT;
            rau_pkg::ST_GCD_SHIFT: begin
                if (r_mag == 64'd0) n_state = rau_pkg::ST_OUT;
                else if (r_ga[0] && r_gb[0]) n_state = rau_pkg::ST_GCD_SUB;
            end
            rau_pkg::ST_GCD_SUB:   n_state = (r_ga == r_gb) ? rau_pkg::ST_DIV_INIT
                                                            : rau_pkg::ST_GCD_SHIFT;
            rau_pkg::ST_DIV_INIT:  n_state = rau_pkg::ST_DIV_NUM;
            rau_pkg::ST_DIV_NUM:   if (r_cnt == 7'd63) n_state = rau_pkg::ST_DIV_DEN;
            rau_pkg::ST_DIV_DEN:   if (r_cnt == 7'd63) n_state = rau_pkg::ST_CHECK;
            rau_pkg::ST_CHECK:     n_state = rau_pkg::ST_OUT;
            rau_pkg::ST_OUT:       if (m_axis_tready) n_state = rau_pkg::ST_IDLE;
            default:               n_state = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::ST_IDLE: begin
                r_op  <= s_axis_tdata[1:0];
                r_ma  <= mag32(in_an[31:0]);
                r_da  <= mag32(in_ad[31:0]);
                r_mb  <= mag32(in_bn[31:0]);
                r_db  <= mag32(in_bd[31:0]);
                r_sa  <= in_an[31] ^ in_ad[31];
                r_sb  <= in_bn[31] ^ in_bd[31];
                r_err <= (in_ad == 64'd0 || in_bd == 64'd0 ||
                          (rau_pkg::t_op'(s_axis_tdata[1:0]) == rau_pkg::OP_DIV &&
                           in_bn == 64'd0)) ? rau_pkg::ERR_ZERO_DEN : rau_pkg::ERR_NONE;
                r_onum <= 32'd0;
                r_oden <= 31'd0;
            end
            rau_pkg::ST_MUL1: r_p <= mul_y;
            rau_pkg::ST_MUL2: r_q <= mul_y;
            rau_pkg::ST_MUL3: r_den <= mul_y;
            rau_pkg::ST_COMBINE: begin
                if (rau_pkg::t_op'(r_op) == rau_pkg::OP_MUL ||
                    rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) begin
                    r_mag <= (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) ? r_p : r_q;
                    r_neg <= r_sa ^ r_sb;
                    r_dsave <= (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) ? r_q : r_den;
                    r_ga <= (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) ? r_p : r_q;
                    r_gb <= (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) ? r_q : r_den;
                end else begin
                    // sign of second term flips for subtract
                    if (r_sa == (r_sb ^ (rau_pkg::t_op'(r_op) == rau_pkg::OP_SUB))) begin
                        r_mag <= r_p + r_q; r_ga <= r_p + r_q; r_neg <= r_sa;
                    end else if (!sub_y[64]) begin
                        r_mag <= sub_y[63:0]; r_ga <= sub_y[63:0]; r_neg <= r_sa;
                    end else begin
                        r_mag <= r_q - r_p; r_ga <= r_q - r_p; r_neg <= ~r_sa;
                    end
                    r_dsave <= r_den;
                    r_gb <= r_den;
                end
                r_k <= 7'd0;
            end
            rau_pkg::ST_GCD_SHIFT: begin
                if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_k <= r_k + 7'd1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end
                if (r_mag == 64'd0) r_oden <= 31'd1;
            end
            rau_pkg::ST_GCD_SUB: begin
                if (!sub_y[64]) r_ga <= sub_y[63:0];
                else r_gb <= r_gb - r_ga;
            end
            rau_pkg::ST_DIV_INIT: begin
                // r_gb still holds the odd part once both operands met
                r_g   <= r_gb << r_k[5:0];
                r_quo <= r_mag;
                r_rem <= 64'd0;
                r_cnt <= 7'd0;
            end
            rau_pkg::ST_DIV_NUM, rau_pkg::ST_DIV_DEN: begin
                if (r_cnt == 7'd63) begin
                    r_cnt <= 7'd0;
                    r_rem <= 64'd0;
                    if (r_state == rau_pkg::ST_DIV_NUM) begin
                        r_rnum <= {r_quo[62:0], ~sub_y[64]};
                        r_quo  <= r_dsave;
                    end else begin
                        r_rden <= {r_quo[62:0], ~sub_y[64]};
                    end
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                    if (!sub_y[64]) begin
                        r_rem <= sub_y[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
            end
            rau_pkg::ST_CHECK: begin
                if (r_rden > LIM || (r_neg ? r_rnum > LIM + 64'd1 : r_rnum > LIM)) begin
                    r_err <= rau_pkg::ERR_OVERFLOW;
                end else begin
                    r_onum <= r_neg ? (32'd0 - r_rnum[31:0]) : r_rnum[31:0];
                    r_oden <= r_rden[30:0];
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == rau_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == rau_pkg::ST_OUT);
    assign m_axis_tdata  = {7'd0, r_err, r_oden, r_onum};

    // an error result always carries a zero fraction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64:63] != 2'd0 |-> m_axis_tdata[62:0] == 63'd0)
        else $error("error result with nonzero payload");

    // a good result has a nonzero denominator
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64:63] == 2'd0 |-> m_axis_tdata[62:32] != 31'd0)
        else $error("zero denominator on good result");

    // never ready while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");

endmodule
